FILE: design/hwss_pkg.sv
package hwss_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int SINE_ENTRIES_DEF = 1024;
  localparam int QUEUE_DEPTH = 4;

  localparam int CFG_INDEX_BITS = 2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_POLARITY = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DITHER_SEED = 2'd1;

  localparam logic [31:0] RESET_SEED = 32'd305419896;

  // q2.30 pi/2, q0.32 2/pi, q2.30 one
  localparam logic [63:0] PIH_Q30 = 64'd1686629713;
  localparam logic [63:0] TWO_OVER_PI_Q32 = 64'd2734261102;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;

endpackage

FILE: design/half_wave_sine_shaper_dither.sv
// path: a sample accepted into the input queue passes the table read and interpolation
// multiply registers in the back end, then the output queue
// throughput: one sample per cycle while the back end's output credit lets it pop
// reset: polarity 0, dither generator loaded with 0x12345678, both queues empty
module half_wave_sine_shaper_dither #(
  parameter int SAMPLE_BITS = hwss_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_ENTRIES = hwss_pkg::SINE_ENTRIES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  input  logic                                in_block_last,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [SAMPLE_BITS-1:0]       out_sample,
  output logic                                out_block_last,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hwss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]                         cfg_data
);
  import hwss_pkg::*;

  localparam int IdxW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic                   shape;
    logic                   inv;
    logic [IdxW-1:0]        idx;
    logic [SAMPLE_BITS-2:0] frac;
    logic [31:0]            rng;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } mid_item_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic                   last;
  } res_item_t;

  logic            mid_push, mid_pop, mid_full, mid_empty;
  logic [CntW-1:0] mid_count;
  mid_item_t       mid_in, mid_head;
  logic            res_push;
  logic [CntW-1:0] res_count;
  res_item_t       res_in, res_head;
  logic            res_full;

  assign cfg_ready = 1'b1;
  assign in_full = mid_full;

  hwss_front #(
    .mid_item_t(mid_item_t),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES)
  ) u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_sample(in_sample),
    .in_block_last(in_block_last),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mid_full(mid_full),
    .mid_push(mid_push),
    .mid_item(mid_in)
  );

  hwss_queue #(
    .item_t(mid_item_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(mid_push),
    .push_item(mid_in),
    .pop(mid_pop),
    .full(mid_full),
    .empty(mid_empty),
    .count(mid_count),
    .head_item(mid_head)
  );

  hwss_back #(
    .mid_item_t(mid_item_t),
    .res_item_t(res_item_t),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SINE_TABLE_ENTRIES(SINE_TABLE_ENTRIES),
    .OUT_DEPTH(QUEUE_DEPTH)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .mid_empty(mid_empty),
    .mid_head(mid_head),
    .mid_pop(mid_pop),
    .out_count(res_count),
    .res_push(res_push),
    .res_item(res_in)
  );

  // the back end only pops when its credit guarantees a free slot here
  hwss_queue #(
    .item_t(res_item_t),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push(res_push),
    .push_item(res_in),
    .pop(out_pop),
    .full(res_full),
    .empty(out_empty),
    .count(res_count),
    .head_item(res_head)
  );

  assign out_sample = res_head.sample;
  assign out_block_last = res_head.last;

endmodule

FILE: design/hwss_queue.sv
module hwss_queue #(
  parameter type item_t = logic,
  parameter int DEPTH = hwss_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  item_t                      push_item,
  input  logic                       pop,
  output logic                       full,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count,
  output item_t                      head_item
);
  import hwss_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  item_t            slot_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full = (count_r == CntW'(DEPTH));
  assign empty = (count_r == '0);
  assign count = count_r;
  assign head_item = slot_r[rd_ptr_r];

  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: design/hwss_front.sv
module hwss_front #(
  parameter type mid_item_t = logic,
  parameter int SAMPLE_BITS = hwss_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_ENTRIES = hwss_pkg::SINE_ENTRIES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_push,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  input  logic                               in_block_last,
  input  logic                               cfg_valid,
  input  logic [hwss_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [31:0]                        cfg_data,
  input  logic                               mid_full,
  output logic                               mid_push,
  output mid_item_t                          mid_item
);
  import hwss_pkg::*;

  localparam int IdxW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int ProdW = SAMPLE_BITS + IdxW;

  logic                    polarity_r, polarity_nxt;
  logic [31:0]             rng_r, rng_nxt;
  logic [31:0]             rng_a, rng_b, rng_step;
  logic [SAMPLE_BITS-1:0]  raw;
  logic [SAMPLE_BITS-1:0]  mag;
  logic                    neg;
  logic                    shape;
  logic [ProdW-1:0]        pos;
  logic                    accept;

  assign raw = in_sample;
  assign neg = raw[SAMPLE_BITS-1];
  assign accept = in_push && !mid_full;
  assign mid_push = accept;

  // shaped half: strictly positive, or negative in inverse polarity
  assign shape = polarity_r ? neg : (!neg && (raw != '0));
  assign mag = polarity_r ? (~raw + 1'b1) : raw;
  assign pos = ProdW'(mag) * ProdW'(SINE_TABLE_ENTRIES);

  // xorshift 13/17/5
  assign rng_a = rng_r ^ (rng_r << 13);
  assign rng_b = rng_a ^ (rng_a >> 17);
  assign rng_step = rng_b ^ (rng_b << 5);

  always_comb begin
    mid_item = '0;
    mid_item.shape = shape;
    mid_item.inv = polarity_r;
    mid_item.idx = pos[SAMPLE_BITS-2+IdxW:SAMPLE_BITS-1];
    mid_item.frac = pos[SAMPLE_BITS-2:0];
    mid_item.rng = rng_step;
    mid_item.sample = raw;
    mid_item.last = in_block_last;
  end

  always_comb begin
    polarity_nxt = polarity_r;
    rng_nxt = rng_r;
    if (accept && shape) begin
      rng_nxt = rng_step;
    end
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_POLARITY: polarity_nxt = cfg_data[0];
        REG_DITHER_SEED: rng_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      polarity_r <= 1'b0;
      rng_r <= RESET_SEED;
    end else begin
      polarity_r <= polarity_nxt;
      rng_r <= rng_nxt;
    end
  end

endmodule

FILE: design/hwss_back.sv
module hwss_back #(
  parameter type mid_item_t = logic,
  parameter type res_item_t = logic,
  parameter int SAMPLE_BITS = hwss_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_ENTRIES = hwss_pkg::SINE_ENTRIES_DEF,
  parameter int OUT_DEPTH = hwss_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           mid_empty,
  input  mid_item_t                      mid_head,
  output logic                           mid_pop,
  input  logic [$clog2(OUT_DEPTH+1)-1:0] out_count,
  output logic                           res_push,
  output res_item_t                      res_item
);
  import hwss_pkg::*;

  localparam int IdxW = $clog2(SINE_TABLE_ENTRIES + 1);
  localparam int FracW = SAMPLE_BITS - 1;
  localparam int ProdW = 32 + FracW;
  localparam int CntW = $clog2(OUT_DEPTH + 1);

  typedef logic [31:0] sine_tab_t [SINE_TABLE_ENTRIES + 1];

  // quarter-wave sin*2/pi in q0.32, taylor series through x^15 in q2.30
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t   tab;
    logic [63:0] th;
    logic [63:0] t2;
    logic [63:0] term;
    longint      sum;
    for (int i = 0; i <= SINE_TABLE_ENTRIES; i++) begin
      th = (64'(i) * PIH_Q30 + 64'(SINE_TABLE_ENTRIES / 2)) / SINE_TABLE_ENTRIES;
      t2 = (th * th) >> 30;
      sum = longint'(th);
      term = th;
      term = ((term * t2) >> 30) / 6;
      sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 20;
      sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 42;
      sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 72;
      sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 110;
      sum = sum - longint'(term);
      term = ((term * t2) >> 30) / 156;
      sum = sum + longint'(term);
      term = ((term * t2) >> 30) / 210;
      sum = sum - longint'(term);
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > longint'(Q30_ONE)) begin
        sum = longint'(Q30_ONE);
      end
      tab[i] = 32'((64'(sum) * TWO_OVER_PI_Q32) >> 30);
    end
    return tab;
  endfunction

  localparam sine_tab_t SineTab = build_sine_tab();

  // stage 1: table read
  logic                    v1_r;
  mid_item_t               s1_r;
  logic [31:0]             lo1_r, hi1_r;
  logic [IdxW-1:0]         idx_hi;

  // stage 2: interpolation product and dithered base
  logic                    v2_r;
  logic                    shape2_r, inv2_r, last2_r;
  logic [SAMPLE_BITS-1:0]  sample2_r;
  logic [ProdW-1:0]        prod2_r;
  logic signed [33:0]      base2_r;

  logic [CntW:0]           used;
  logic [31:0]             diff;
  logic signed [31:0]      dith;
  logic [31:0]             interp;
  logic signed [33:0]      total;
  logic [32:0]             clamped;
  logic [32:0]             qfull;
  logic [SAMPLE_BITS-1:0]  qmag;

  // credit: results in flight plus queued never exceed the output queue
  assign used = (CntW+1)'(out_count) + (CntW+1)'(v1_r) + (CntW+1)'(v2_r);
  assign mid_pop = !mid_empty && (used < (CntW+1)'(OUT_DEPTH));

  assign idx_hi = (mid_head.idx == IdxW'(SINE_TABLE_ENTRIES)) ? mid_head.idx
                                                              : mid_head.idx + 1'b1;

  assign diff = (hi1_r >= lo1_r) ? hi1_r - lo1_r : '0;
  // floor of the signed generator value over 2^(bits-1)
  assign dith = $signed(s1_r.rng) >>> FracW;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= mid_pop;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      s1_r <= mid_head;
      lo1_r <= SineTab[mid_head.idx];
      hi1_r <= SineTab[idx_hi];
    end
    if (v1_r) begin
      shape2_r <= s1_r.shape;
      inv2_r <= s1_r.inv;
      last2_r <= s1_r.last;
      sample2_r <= s1_r.sample;
      prod2_r <= ProdW'(diff) * ProdW'(s1_r.frac);
      base2_r <= $signed({2'b00, lo1_r}) + 34'(dith);
    end
  end

  assign interp = 32'(prod2_r >> FracW);
  assign total = base2_r + $signed({2'b00, interp});
  assign clamped = total[33] ? '0 : total[32:0];
  assign qfull = clamped >> (33 - SAMPLE_BITS);
  assign qmag = qfull[SAMPLE_BITS-1:0];

  assign res_push = v2_r;

  always_comb begin
    res_item = '0;
    res_item.last = last2_r;
    if (!shape2_r) begin
      res_item.sample = sample2_r;
    end else if (inv2_r) begin
      res_item.sample = ~qmag + 1'b1;
    end else begin
      res_item.sample = qmag;
    end
  end

endmodule
